[sv/hcd_pkg.sv]
// ---------------------------------------------------------------------------
// hcd_pkg: shared types and constants for the chunked body decoder
// Holds the parse phase and status codes, character constants and the
// hex digit decoder.
// ---------------------------------------------------------------------------
package hcd_pkg;

   localparam int SIZE_BITS  = 32;
   localparam int COUNT_BITS = 33;
   localparam int LIMIT_BITS = 32;

   localparam logic [LIMIT_BITS-1:0] MAX_BODY_RESET = LIMIT_BITS'(1048576);

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   typedef enum logic [1:0] {
      ST_BUSY     = 2'd0,
      ST_DONE     = 2'd1,
      ST_INVALID  = 2'd2,
      ST_TOOLARGE = 2'd3
   } status_type;

   typedef enum logic [10:0] {
      PH_SIZE      = 11'b000_0000_0001,
      PH_SIZE_LF   = 11'b000_0000_0010,
      PH_EXT       = 11'b000_0000_0100,
      PH_EXT_LF    = 11'b000_0000_1000,
      PH_DATA      = 11'b000_0001_0000,
      PH_DATA_CR   = 11'b000_0010_0000,
      PH_DATA_LF   = 11'b000_0100_0000,
      PH_TRL_START = 11'b000_1000_0000,
      PH_TRL_SLF   = 11'b001_0000_0000,
      PH_TRL_LINE  = 11'b010_0000_0000,
      PH_TRL_LF    = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   // Decode one ASCII hex digit; ok is low for any other byte.
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.value = c[3:0] + 4'd9;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

[sv/hcd_channels.sv]
// ---------------------------------------------------------------------------
// hcd channels: valid/ready interfaces for raw and decoded bytes
// One transfer moves when valid and ready are both high at a clock edge.
// ---------------------------------------------------------------------------
interface hcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       message_start;

   modport source (output valid, output data_byte, output message_start, input ready);
   modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface hcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [1:0] status;

   modport source (output valid, output payload_valid, output payload_byte,
                   output status, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input status, output ready);
endinterface

[sv/http_chunked_decoder_top.sv]
// ---------------------------------------------------------------------------
// http_chunked_decoder_top: HTTP/1.1 chunked body decoder
// Strips chunk framing from a raw body stream, one byte per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries raw body bytes; message_start high on the first byte of
//   a message clears the parser (the size limit is kept).
//   rsp_ch returns exactly one result per raw byte, in order: a decoded
//   payload byte when payload_valid is high, and the sticky status after
//   that byte (0 in progress, 1 complete, 2 invalid, 3 too large).
//   csr_wr_en/csr_wr_data write the body size limit (reset 1 MiB); write
//   it only while no transfer is in flight.
// Timing:
//   A req transfer fills an input register, then one pass of the framing
//   state machine loads the result register that drives rsp valid.
//   Throughput is one byte per cycle while the receiver does not stall.
// Reset and stalls:
//   Synchronous reset empties both registers and returns the parser to the
//   start of a size line. When the receiver stalls, the result register
//   holds; req_ch.ready drops as soon as the input register is full too,
//   so at most two bytes wait inside the block.
// ---------------------------------------------------------------------------
module http_chunked_decoder_top
   import hcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   hcd_req_if.sink               req_ch,
   hcd_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_BITS-1:0] csr_wr_data
);

   hcd_req_if staged_ch ();
   hcd_rsp_if result_ch ();

   // Register the incoming byte.
   hcd_in_reg u_in_reg (
      .clock  (clock),
      .reset  (reset),
      .in_ch  (req_ch),
      .out_ch (staged_ch)
   );

   // Advance the framing state and form the result.
   hcd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_ch       (staged_ch),
      .out_ch      (result_ch)
   );

   // Hold the result for the receiver.
   hcd_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .in_ch  (result_ch),
      .out_ch (rsp_ch)
   );

endmodule

[sv/hcd_in_reg.sv]
// ---------------------------------------------------------------------------
// hcd_in_reg: input register for raw bytes
// Hold one raw byte; take a new one whenever the held one moves on.
// ---------------------------------------------------------------------------
module hcd_in_reg
   import hcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hcd_req_if.sink      in_ch,
   hcd_req_if.source    out_ch
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;

   assign in_ch.ready = !valid_ff || out_ch.ready;
   assign valid_in    = in_ch.valid || (valid_ff && !out_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads on every accepted transfer.
   always_ff @(posedge clock) begin
      if (in_ch.valid && in_ch.ready) begin
         byte_ff  <= in_ch.data_byte;
         start_ff <= in_ch.message_start;
      end
   end

   assign out_ch.valid         = valid_ff;
   assign out_ch.data_byte     = byte_ff;
   assign out_ch.message_start = start_ff;

endmodule

[sv/hcd_parser.sv]
// ---------------------------------------------------------------------------
// hcd_parser: chunk framing state machine
// Advance the parse state by one byte per transfer and form the result.
// ---------------------------------------------------------------------------
module hcd_parser
   import hcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_BITS-1:0] csr_wr_data,
   hcd_req_if.sink               in_ch,
   hcd_rsp_if.source             out_ch
);

   phase_type             phase_ff, phase_in;
   logic [SIZE_BITS-1:0]  remaining_ff, remaining_in;
   logic                  digit_seen_ff, digit_seen_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   status_type            status_ff, status_in;
   logic [LIMIT_BITS-1:0] max_body_ff;

   phase_type             cur_phase;
   logic [SIZE_BITS-1:0]  cur_remaining;
   logic                  cur_digit_seen;
   logic [COUNT_BITS-1:0] cur_count;
   status_type            cur_status;
   hex_digit_type         hex;
   logic [SIZE_BITS-1:0]  rem_dec;
   logic                  pay_valid;
   logic [7:0]            pay_byte;
   logic [7:0]            c;
   logic                  fire;

   assign c      = in_ch.data_byte;
   assign hex    = hex_decode(c);
   assign fire   = in_ch.valid && in_ch.ready;

   assign out_ch.valid  = in_ch.valid;
   assign in_ch.ready   = out_ch.ready;

   always_comb begin
      // A message start clears the parser before the byte is looked at.
      if (in_ch.message_start) begin
         cur_phase      = PH_SIZE;
         cur_remaining  = '0;
         cur_digit_seen = 1'b0;
         cur_count      = '0;
         cur_status     = ST_BUSY;
      end else begin
         cur_phase      = phase_ff;
         cur_remaining  = remaining_ff;
         cur_digit_seen = digit_seen_ff;
         cur_count      = count_ff;
         cur_status     = status_ff;
      end

      phase_in      = cur_phase;
      remaining_in  = cur_remaining;
      digit_seen_in = cur_digit_seen;
      count_in      = cur_count;
      status_in     = cur_status;
      pay_valid     = 1'b0;
      pay_byte      = 8'd0;
      rem_dec       = cur_remaining - SIZE_BITS'(1);

      if (cur_status == ST_BUSY) begin
         unique case (cur_phase)
            PH_SIZE: begin
               if (hex.ok) begin
                  if (cur_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
                     status_in = ST_INVALID;
                  end else begin
                     remaining_in  = {cur_remaining[SIZE_BITS-5:0], hex.value};
                     digit_seen_in = 1'b1;
                  end
               end else if (c == CH_SEMI && cur_digit_seen) begin
                  phase_in = PH_EXT;
               end else if (c == CH_CR && cur_digit_seen) begin
                  phase_in = PH_SIZE_LF;
               end else begin
                  status_in = ST_INVALID;
               end
            end
            PH_SIZE_LF: begin
               if (c == CH_LF) begin
                  phase_in = (cur_remaining == '0) ? PH_TRL_START : PH_DATA;
               end else begin
                  status_in = ST_INVALID;
               end
            end
            PH_EXT: begin
               if (c == CH_CR) phase_in = PH_EXT_LF;
            end
            PH_EXT_LF: begin
               if (c == CH_LF) begin
                  phase_in = (cur_remaining == '0) ? PH_TRL_START : PH_DATA;
               end else if (c != CH_CR) begin
                  phase_in = PH_EXT;
               end
            end
            PH_DATA: begin
               if (cur_count >= {1'b0, max_body_ff}) begin
                  status_in = ST_TOOLARGE;
               end else begin
                  count_in     = cur_count + COUNT_BITS'(1);
                  pay_valid    = 1'b1;
                  pay_byte     = c;
                  remaining_in = rem_dec;
                  if (rem_dec == '0) phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (c == CH_CR) phase_in = PH_DATA_LF;
               else status_in = ST_INVALID;
            end
            PH_DATA_LF: begin
               if (c == CH_LF) begin
                  phase_in      = PH_SIZE;
                  remaining_in  = '0;
                  digit_seen_in = 1'b0;
               end else begin
                  status_in = ST_INVALID;
               end
            end
            PH_TRL_START: begin
               phase_in = (c == CH_CR) ? PH_TRL_SLF : PH_TRL_LINE;
            end
            PH_TRL_SLF: begin
               if (c == CH_LF) status_in = ST_DONE;
               else phase_in = (c == CH_CR) ? PH_TRL_LF : PH_TRL_LINE;
            end
            PH_TRL_LINE: begin
               if (c == CH_CR) phase_in = PH_TRL_LF;
            end
            PH_TRL_LF: begin
               if (c == CH_LF) phase_in = PH_TRL_START;
               else if (c != CH_CR) phase_in = PH_TRL_LINE;
            end
            default: begin
               status_in = ST_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         remaining_ff  <= '0;
         digit_seen_ff <= 1'b0;
         count_ff      <= '0;
         status_ff     <= ST_BUSY;
      end else if (fire) begin
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         digit_seen_ff <= digit_seen_in;
         count_ff      <= count_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= MAX_BODY_RESET;
      end else if (csr_wr_en) begin
         max_body_ff <= csr_wr_data;
      end
   end

   assign out_ch.payload_valid = pay_valid;
   assign out_ch.payload_byte  = pay_byte;
   assign out_ch.status        = status_in;

   // Decoded bytes only ever leave while the message is still in progress.
   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      pay_valid |-> (status_in == ST_BUSY))
      else $error("payload byte emitted with terminal status");

   // Phase register stays one-hot.
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("parse phase not one-hot");

   // A terminal status sticks until the next message start.
   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      (fire && !in_ch.message_start && status_ff != ST_BUSY)
      |=> (status_ff == $past(status_ff)))
      else $error("terminal status changed without message start");

endmodule

[sv/hcd_out_reg.sv]
// ---------------------------------------------------------------------------
// hcd_out_reg: result register
// Hold one result until the receiver takes it; refill in the same cycle.
// ---------------------------------------------------------------------------
module hcd_out_reg
   import hcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hcd_rsp_if.sink      in_ch,
   hcd_rsp_if.source    out_ch
);

   logic       valid_ff;
   logic       valid_in;
   logic       pay_valid_ff;
   logic [7:0] pay_byte_ff;
   status_type status_ff;

   assign in_ch.ready = !valid_ff || out_ch.ready;
   assign valid_in    = in_ch.valid || (valid_ff && !out_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ch.valid && in_ch.ready) begin
         pay_valid_ff <= in_ch.payload_valid;
         pay_byte_ff  <= in_ch.payload_byte;
         status_ff    <= status_type'(in_ch.status);
      end
   end

   assign out_ch.valid         = valid_ff;
   assign out_ch.payload_valid = pay_valid_ff;
   assign out_ch.payload_byte  = pay_byte_ff;
   assign out_ch.status        = status_ff;

endmodule
